/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the midpoint line rasterizer.
// No dependencies; the checks drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Implication or plain property, checked at each rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// A condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/mlr_pkg.sv */
// Shared types and constants for the midpoint line rasterizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

	// Default coordinate width of the endpoints and the emitted pixels.
	localparam int COORD_BITS_DEF = 12;

	// Command codes of an input transaction.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Octant of a line, counted counterclockwise from the x-major positive slope.
	typedef enum logic [2:0] {
		OCT_0 = 3'd0,
		OCT_1 = 3'd1,
		OCT_2 = 3'd2,
		OCT_3 = 3'd3,
		OCT_4 = 3'd4,
		OCT_5 = 3'd5,
		OCT_6 = 3'd6,
		OCT_7 = 3'd7
	} octant_t;

endpackage

`default_nettype wire

/* rtl/mlr_setup.sv */
// Line setup: octant classification, mapping into octant 0 and decision terms.
// Purely combinational; depends on mlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlr_setup #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	output mlr_pkg::octant_t             octant,
	output logic signed [COORD_BITS:0]   walk_x,
	output logic signed [COORD_BITS:0]   walk_y,
	output logic signed [COORD_BITS:0]   stop_x,
	output logic signed [COORD_BITS+2:0] decision,
	output logic [COORD_BITS+1:0]        step_east,
	output logic signed [COORD_BITS+2:0] step_diag,
	output logic                         busy
);
	import mlr_pkg::*;

	localparam int W = COORD_BITS + 1;
	localparam int D = COORD_BITS + 3;

	logic signed [W-1:0] xs_w;
	logic signed [W-1:0] ys_w;
	logic signed [W-1:0] xe_w;
	logic signed [W-1:0] ye_w;
	logic signed [W-1:0] dx;
	logic signed [W-1:0] dy;
	logic signed [W-1:0] ax;
	logic signed [W-1:0] ay;
	logic                x_major;
	logic signed [W-1:0] end_v;
	logic signed [D-1:0] ddx;
	logic signed [D-1:0] ddy;
	logic signed [D-1:0] ddy2;

	// Maps a point of the given octant into octant-0 space.
	function automatic logic [2*W-1:0] to_zero(octant_t oct, logic signed [W-1:0] x,
			logic signed [W-1:0] y);
		logic signed [W-1:0] u;
		logic signed [W-1:0] v;
		unique case (oct)
			OCT_0: begin u = x;  v = y;  end
			OCT_1: begin u = y;  v = x;  end
			OCT_2: begin u = y;  v = -x; end
			OCT_3: begin u = -x; v = y;  end
			OCT_4: begin u = -x; v = -y; end
			OCT_5: begin u = -y; v = -x; end
			OCT_6: begin u = -y; v = x;  end
			OCT_7: begin u = x;  v = -y; end
		endcase
		return {u, v};
	endfunction

	// Endpoints widened by one bit so that negation never overflows.
	assign xs_w = W'(x_start);
	assign ys_w = W'(y_start);
	assign xe_w = W'(x_end);
	assign ye_w = W'(y_end);
	assign dx   = xe_w - xs_w;
	assign dy   = ye_w - ys_w;
	assign ax   = dx[W-1] ? -dx : dx;
	assign ay   = dy[W-1] ? -dy : dy;
	assign x_major = ax > ay;

	// Octant from the signs of the deltas and which of them dominates.
	always_comb begin
		if (!dx[W-1] && !dy[W-1]) begin
			octant = x_major ? OCT_0 : OCT_1;
		end else if (!dx[W-1]) begin
			octant = x_major ? OCT_7 : OCT_6;
		end else if (dy[W-1]) begin
			octant = x_major ? OCT_4 : OCT_5;
		end else begin
			octant = x_major ? OCT_3 : OCT_2;
		end
	end

	// Both endpoints in octant-0 space.
	assign {walk_x, walk_y} = to_zero(octant, xs_w, ys_w);
	assign {stop_x, end_v}  = to_zero(octant, xe_w, ye_w);

	// Initial decision value and its east and north-east increments.
	assign ddx       = D'(stop_x) - D'(walk_x);
	assign ddy       = D'(end_v) - D'(walk_y);
	assign ddy2      = ddy <<< 1;
	assign decision  = ddy2 - ddx;
	assign step_east = ddy2[COORD_BITS+1:0];
	assign step_diag = (ddy - ddx) <<< 1;
	assign busy      = walk_x < stop_x;

endmodule

`default_nettype wire

/* rtl/mlr_core.sv */
// Walk state of the rasterizer: one midpoint step per tick, mapped back to real space.
// Depends on mlr_pkg; takes the setup terms from mlr_setup.
`timescale 1ns / 1ps
`default_nettype none

module mlr_core #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         load,
	input  mlr_pkg::octant_t             set_octant,
	input  logic signed [COORD_BITS:0]   set_walk_x,
	input  logic signed [COORD_BITS:0]   set_walk_y,
	input  logic signed [COORD_BITS:0]   set_stop_x,
	input  logic signed [COORD_BITS+2:0] set_decision,
	input  logic [COORD_BITS+1:0]        set_step_east,
	input  logic signed [COORD_BITS+2:0] set_step_diag,
	input  logic                         set_busy,
	output logic                         res_valid,
	output logic signed [COORD_BITS-1:0] res_x,
	output logic signed [COORD_BITS-1:0] res_y,
	output logic                         res_last,
	output logic                         busy
);
	import mlr_pkg::*;

	localparam int W = COORD_BITS + 1;
	localparam int D = COORD_BITS + 3;
	localparam logic signed [W-1:0] ONE_W = W'(1);

	octant_t             octant_q,    octant_n;
	logic signed [W-1:0] walk_x_q,    walk_x_n;
	logic signed [W-1:0] walk_y_q,    walk_y_n;
	logic signed [W-1:0] stop_x_q,    stop_x_n;
	logic signed [D-1:0] decision_q,  decision_n;
	logic [D-2:0]        step_east_q, step_east_n;
	logic signed [D-1:0] step_diag_q, step_diag_n;
	logic                busy_q,      busy_n;
	logic signed [W-1:0] px;
	logic signed [W-1:0] py;

	// Maps an octant-0 point back into real coordinates.
	function automatic logic [2*W-1:0] from_zero(octant_t oct, logic signed [W-1:0] u,
			logic signed [W-1:0] v);
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		unique case (oct)
			OCT_0: begin x = u;  y = v;  end
			OCT_1: begin x = v;  y = u;  end
			OCT_2: begin x = -v; y = u;  end
			OCT_3: begin x = -u; y = v;  end
			OCT_4: begin x = -u; y = -v; end
			OCT_5: begin x = -v; y = -u; end
			OCT_6: begin x = v;  y = -u; end
			OCT_7: begin x = u;  y = -v; end
		endcase
		return {x, y};
	endfunction

	// Next state: a load takes the setup terms, a tick on an active line steps once.
	always_comb begin
		octant_n    = octant_q;
		walk_x_n    = walk_x_q;
		walk_y_n    = walk_y_q;
		stop_x_n    = stop_x_q;
		decision_n  = decision_q;
		step_east_n = step_east_q;
		step_diag_n = step_diag_q;
		busy_n      = busy_q;
		res_valid   = 1'b0;
		if (advance) begin
			if (load) begin
				octant_n    = set_octant;
				walk_x_n    = set_walk_x;
				walk_y_n    = set_walk_y;
				stop_x_n    = set_stop_x;
				decision_n  = set_decision;
				step_east_n = set_step_east;
				step_diag_n = set_step_diag;
				busy_n      = set_busy;
				res_valid   = 1'b1;
			end else if (busy_q) begin
				if (decision_q[D-1]) begin
					decision_n = decision_q + $signed({1'b0, step_east_q});
				end else begin
					walk_y_n   = walk_y_q + ONE_W;
					decision_n = decision_q + step_diag_q;
				end
				walk_x_n  = walk_x_q + ONE_W;
				busy_n    = walk_x_n < stop_x_q;
				res_valid = 1'b1;
			end
		end
	end

	// The emitted pixel is the updated point in real coordinates.
	assign {px, py}  = from_zero(octant_n, walk_x_n, walk_y_n);
	assign res_x     = px[COORD_BITS-1:0];
	assign res_y     = py[COORD_BITS-1:0];
	assign res_last  = !busy_n;
	assign busy      = busy_q;

	// Walk state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octant_q    <= OCT_0;
			walk_x_q    <= '0;
			walk_y_q    <= '0;
			stop_x_q    <= '0;
			decision_q  <= '0;
			step_east_q <= '0;
			step_diag_q <= '0;
			busy_q      <= 1'b0;
		end else begin
			octant_q    <= octant_n;
			walk_x_q    <= walk_x_n;
			walk_y_q    <= walk_y_n;
			stop_x_q    <= stop_x_n;
			decision_q  <= decision_n;
			step_east_q <= step_east_n;
			step_diag_q <= step_diag_n;
			busy_q      <= busy_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/midpoint_line_rasterizer.sv */
// Midpoint line rasterizer: input register, line setup, walk state and result register.
// Depends on mlr_pkg, mlr_setup, mlr_core and assert_macros.svh.
//
// Usage: the input channel (in_valid / in_stall) carries one command per transaction.
// A load command (command = 0) takes x_start, y_start, x_end, y_end, replaces any line
// in progress and emits the start pixel at once. Each tick command (command = 1) steps
// one pixel along the line and emits it; last_pixel marks the end point. A tick with no
// line in progress produces nothing, and the endpoint fields are ignored on ticks.
// The output channel (out_valid / out_stall) carries pixel_x, pixel_y and last_pixel.
// A result passes through the input register and then the result register before it
// appears on the output.
// Throughput: one transaction per cycle unless out_stall holds a result; each tick is a
// single add and compare on the walk registers.
// When out_stall holds a result, one more transaction is taken into the input register
// and in_stall then rises until the output drains. Payloads hold while stalled.
// Reset (arst_n low) empties both registers and ends any line in progress.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module midpoint_line_rasterizer #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         last_pixel
);
	import mlr_pkg::*;

	logic                         s1_valid_q;
	logic                         command_s1;
	logic signed [COORD_BITS-1:0] x_start_s1;
	logic signed [COORD_BITS-1:0] y_start_s1;
	logic signed [COORD_BITS-1:0] x_end_s1;
	logic signed [COORD_BITS-1:0] y_end_s1;
	logic                         out_free;
	logic                         advance;
	logic                         is_load;
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] pixel_x_q;
	logic signed [COORD_BITS-1:0] pixel_y_q;
	logic                         last_pixel_q;

	octant_t                      set_octant;
	logic signed [COORD_BITS:0]   set_walk_x;
	logic signed [COORD_BITS:0]   set_walk_y;
	logic signed [COORD_BITS:0]   set_stop_x;
	logic signed [COORD_BITS+2:0] set_decision;
	logic [COORD_BITS+1:0]        set_step_east;
	logic signed [COORD_BITS+2:0] set_step_diag;
	logic                         set_busy;
	logic                         res_valid;
	logic signed [COORD_BITS-1:0] res_x;
	logic signed [COORD_BITS-1:0] res_y;
	logic                         res_last;
	logic                         core_busy;

	// Flow control: the held transaction moves on whenever the result register can take it.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign is_load  = (command_s1 == CMD_LOAD);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			x_start_s1 <= x_start;
			y_start_s1 <= y_start;
			x_end_s1   <= x_end;
			y_end_s1   <= y_end;
		end
	end

	// Setup terms for a load transaction.
	mlr_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.x_start  (x_start_s1),
		.y_start  (y_start_s1),
		.x_end    (x_end_s1),
		.y_end    (y_end_s1),
		.octant   (set_octant),
		.walk_x   (set_walk_x),
		.walk_y   (set_walk_y),
		.stop_x   (set_stop_x),
		.decision (set_decision),
		.step_east(set_step_east),
		.step_diag(set_step_diag),
		.busy     (set_busy)
	);

	// Walk state and pixel generation.
	mlr_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.load         (is_load),
		.set_octant   (set_octant),
		.set_walk_x   (set_walk_x),
		.set_walk_y   (set_walk_y),
		.set_stop_x   (set_stop_x),
		.set_decision (set_decision),
		.set_step_east(set_step_east),
		.set_step_diag(set_step_diag),
		.set_busy     (set_busy),
		.res_valid    (res_valid),
		.res_x        (res_x),
		.res_y        (res_y),
		.res_last     (res_last),
		.busy         (core_busy)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			pixel_x_q    <= res_x;
			pixel_y_q    <= res_y;
			last_pixel_q <= res_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign last_pixel = last_pixel_q;

	// A result is produced only by a transaction that moves on.
	`ASSERT_CLK(a_result_needs_advance, clk, arst_n, res_valid |-> advance)
	// A tick with no line in progress produces no result.
	`ASSERT_NEVER(a_idle_tick_silent, clk, arst_n, res_valid && !is_load && !core_busy)
	// While the end pixel waits in the result register, no line is in progress.
	`ASSERT_CLK(a_last_ends_line, clk, arst_n, (out_valid_q && last_pixel_q) |-> !core_busy)

endmodule

`default_nettype wire
